FILE: design/sbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_pkg: shared types and constants of the source bracket matcher
// Character codes, scanner modes, report status codes and the control and
// report records passed between the modules.
// ----------------------------------------------------------------------------
package sbm_pkg;

	localparam int DEFAULT_STACK_DEPTH = 256;
	localparam int DEFAULT_LINE_BITS   = 16;
	localparam int OUT_LINE_W          = 16;

	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		MODE_NORMAL     = 3'd0,
		MODE_SLASH      = 3'd1,
		MODE_LINE_CMT   = 3'd2,
		MODE_BLOCK_CMT  = 3'd3,
		MODE_BLOCK_STAR = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ST_BALANCED   = 3'd0,
		ST_NO_OPENER  = 3'd1,
		ST_WRONG_KIND = 3'd2,
		ST_LEFT_OPEN  = 3'd3,
		ST_OVERFLOW   = 3'd4
	} status_t;

	// shift control for the stack row
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

	typedef struct packed {
		status_t                 status;
		logic [7:0]              offending_char;
		logic [OUT_LINE_W-1:0]   line_number;
	} result_t;

endpackage : sbm_pkg
`default_nettype wire

FILE: design/sbm_text_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_text_if: source text channel
// One source byte per transfer, with an end-of-file mark.
// ----------------------------------------------------------------------------
interface sbm_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_file;

	modport source (output valid, output text_byte, output end_of_file, input ready);
	modport sink   (input valid, input text_byte, input end_of_file, output ready);
endinterface : sbm_text_if
`default_nettype wire

FILE: design/sbm_report_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_report_if: status report channel
// One bracket status report per transfer.
// ----------------------------------------------------------------------------
interface sbm_report_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  offending_char;
	logic [15:0] line_number;

	modport source (output valid, output status, output offending_char,
		output line_number, input ready);
	modport sink   (input valid, input status, input offending_char,
		input line_number, output ready);
endinterface : sbm_report_if
`default_nettype wire

FILE: design/source_bracket_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// A report is written into the output queue as the byte that causes it is taken.
// Throughput: one byte per cycle while the queue is not full; each byte does
// at most one push or pop on the shifting cell row, which is the per-byte critical step.
// Reports wait in a two-entry queue, so input stalls only when it is full.
// Reset (arst_n low) clears mode, stack fill, line count and the fault latch;
// the byte that ends a file returns the same state for the next file.
// ----------------------------------------------------------------------------
// source_bracket_matcher: paren and brace balance checker for C source
// Skips comments, counts lines and reports the first bracket fault or the
// final status of each file.
// ----------------------------------------------------------------------------
module source_bracket_matcher #(
	parameter int STACK_DEPTH = sbm_pkg::DEFAULT_STACK_DEPTH,
	parameter int LINE_BITS   = sbm_pkg::DEFAULT_LINE_BITS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sbm_text_if.sink     text,
	sbm_report_if.source report
);

	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	// only the kind is kept per cell; the outermost opener's line has its own register
	localparam int ENTRY_W = 1;

	sbm_pkg::mode_t      mode_q, mode_d;
	logic [CNT_W-1:0]    count_q, count_after;
	logic [LINE_BITS-1:0] line_q;
	logic                fault_q;
	logic                bottom_kind_q, bottom_kind_after;
	logic [LINE_BITS-1:0] bottom_line_q, bottom_line_after;

	logic                accept, act;
	logic [7:0]          c;
	logic                eof;
	logic                normal, line_inc, push, pop, fault;
	sbm_pkg::status_t    fault_status;
	logic                is_nl, is_opener, is_closer;
	logic                stack_full, stack_empty;
	logic                new_kind;
	logic                top_kind;
	logic [ENTRY_W-1:0]  top_entry;
	sbm_pkg::stk_ctl_t   stk_ctl;
	sbm_pkg::result_t    res;
	logic                res_push;
	logic                q_full;

	assign c      = text.text_byte;
	assign eof    = text.end_of_file;
	assign accept = text.valid && text.ready;
	assign act    = accept && !fault_q;
	assign text.ready = !q_full;

	assign is_nl       = (c == sbm_pkg::CH_NEWLINE);
	assign is_opener   = (c == sbm_pkg::CH_LPAREN) || (c == sbm_pkg::CH_LBRACE);
	assign is_closer   = (c == sbm_pkg::CH_RPAREN) || (c == sbm_pkg::CH_RBRACE);
	assign new_kind    = (c == sbm_pkg::CH_LBRACE);
	assign stack_full  = (count_q == CNT_W'(STACK_DEPTH));
	assign stack_empty = (count_q == '0);
	assign top_kind    = top_entry[0];

	always_comb begin
		mode_d       = mode_q;
		normal       = 1'b0;
		line_inc     = 1'b0;
		push         = 1'b0;
		pop          = 1'b0;
		fault        = 1'b0;
		fault_status = sbm_pkg::ST_BALANCED;
		unique case (mode_q)
			sbm_pkg::MODE_SLASH: begin
				if (c == sbm_pkg::CH_SLASH) begin
					mode_d = sbm_pkg::MODE_LINE_CMT;
				end else if (c == sbm_pkg::CH_STAR) begin
					mode_d = sbm_pkg::MODE_BLOCK_CMT;
				end else begin
					mode_d = sbm_pkg::MODE_NORMAL;
					normal = 1'b1;
				end
			end
			sbm_pkg::MODE_LINE_CMT: begin
				if (is_nl) begin
					line_inc = 1'b1;
					mode_d   = sbm_pkg::MODE_NORMAL;
				end
			end
			sbm_pkg::MODE_BLOCK_CMT: begin
				if (c == sbm_pkg::CH_STAR) begin
					mode_d = sbm_pkg::MODE_BLOCK_STAR;
				end else if (is_nl) begin
					line_inc = 1'b1;
				end
			end
			sbm_pkg::MODE_BLOCK_STAR: begin
				if (c == sbm_pkg::CH_SLASH) begin
					mode_d = sbm_pkg::MODE_NORMAL;
				end else if (c != sbm_pkg::CH_STAR) begin
					line_inc = is_nl;
					mode_d   = sbm_pkg::MODE_BLOCK_CMT;
				end
			end
			default: begin
				mode_d = sbm_pkg::MODE_NORMAL;
				normal = 1'b1;
			end
		endcase

		if (normal) begin
			if (c == sbm_pkg::CH_SLASH) begin
				mode_d = sbm_pkg::MODE_SLASH;
			end else if (is_nl) begin
				line_inc = 1'b1;
			end else if (is_opener) begin
				if (stack_full) begin
					fault        = 1'b1;
					fault_status = sbm_pkg::ST_OVERFLOW;
				end else begin
					push = 1'b1;
				end
			end else if (is_closer) begin
				if (stack_empty) begin
					fault        = 1'b1;
					fault_status = sbm_pkg::ST_NO_OPENER;
				end else begin
					pop = 1'b1;
					if (top_kind != (c == sbm_pkg::CH_RBRACE)) begin
						fault        = 1'b1;
						fault_status = sbm_pkg::ST_WRONG_KIND;
					end
				end
			end
		end
	end

	// fill level and outermost opener as they stand after this byte
	always_comb begin
		count_after = count_q;
		if (push) begin
			count_after = count_q + CNT_W'(1);
		end else if (pop) begin
			count_after = count_q - CNT_W'(1);
		end
		bottom_kind_after = bottom_kind_q;
		bottom_line_after = bottom_line_q;
		if (push && stack_empty) begin
			bottom_kind_after = new_kind;
			bottom_line_after = line_q;
		end
	end

	assign stk_ctl.push = act && push;
	assign stk_ctl.pop  = act && pop;

	sbm_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.ENTRY_W     (ENTRY_W)
	) u_stack (
		.clk        (clk),
		.ctl        (stk_ctl),
		.push_entry (new_kind),
		.top_entry  (top_entry)
	);

	always_ff @(posedge clk) begin
		if (act && push && stack_empty) begin
			bottom_kind_q <= new_kind;
			bottom_line_q <= line_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= sbm_pkg::MODE_NORMAL;
			count_q <= '0;
			line_q  <= LINE_BITS'(1);
			fault_q <= 1'b0;
		end else if (accept) begin
			if (eof) begin
				mode_q  <= sbm_pkg::MODE_NORMAL;
				count_q <= '0;
				line_q  <= LINE_BITS'(1);
				fault_q <= 1'b0;
			end else if (!fault_q) begin
				mode_q  <= mode_d;
				count_q <= count_after;
				if (line_inc && (line_q != {LINE_BITS{1'b1}})) begin
					line_q <= line_q + LINE_BITS'(1);
				end
				fault_q <= fault;
			end
		end
	end

	always_comb begin
		if (fault) begin
			res.status         = fault_status;
			res.offending_char = c;
			res.line_number    = sbm_pkg::OUT_LINE_W'(line_q);
		end else if (count_after != '0) begin
			res.status         = sbm_pkg::ST_LEFT_OPEN;
			res.offending_char = bottom_kind_after ? sbm_pkg::CH_LBRACE : sbm_pkg::CH_LPAREN;
			res.line_number    = sbm_pkg::OUT_LINE_W'(bottom_line_after);
		end else begin
			res.status         = sbm_pkg::ST_BALANCED;
			res.offending_char = 8'h00;
			res.line_number    = '0;
		end
	end

	assign res_push = act && (fault || eof);

	sbm_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res),
		.full   (q_full),
		.report (report)
	);

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack fill beyond depth");

	a_eof_clears : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && eof) |=> (count_q == '0 && line_q == LINE_BITS'(1) && !fault_q
			&& mode_q == sbm_pkg::MODE_NORMAL))
		else $error("end of file did not restore initial state");

	a_fault_latches : assert property (@(posedge clk) disable iff (!arst_n)
		(act && fault && !eof) |=> fault_q)
		else $error("fault not latched");

	a_latched_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |-> (!stk_ctl.push && !stk_ctl.pop && !res_push))
		else $error("activity after a latched fault");

endmodule : source_bracket_matcher
`default_nettype wire

FILE: design/sbm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_cell: one stack cell
// Holds one opener entry; loads from the cell above on push and from the
// cell below on pop.
// ----------------------------------------------------------------------------
module sbm_cell #(
	parameter int ENTRY_W = 17
) (
	input  wire logic                 clk,
	input  wire sbm_pkg::stk_ctl_t    ctl,
	input  wire logic [ENTRY_W-1:0]   from_prev,
	input  wire logic [ENTRY_W-1:0]   from_next,
	output logic      [ENTRY_W-1:0]   entry
);

	logic [ENTRY_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= from_prev;
		end else if (ctl.pop) begin
			entry_q <= from_next;
		end
	end

	assign entry = entry_q;

endmodule : sbm_cell
`default_nettype wire

FILE: design/sbm_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_stack: shifting stack of opener entries
// A row of cells; the top of stack always sits in cell 0.
// ----------------------------------------------------------------------------
module sbm_stack #(
	parameter int STACK_DEPTH = sbm_pkg::DEFAULT_STACK_DEPTH,
	parameter int ENTRY_W     = 17
) (
	input  wire logic                 clk,
	input  wire sbm_pkg::stk_ctl_t    ctl,
	input  wire logic [ENTRY_W-1:0]   push_entry,
	output logic      [ENTRY_W-1:0]   top_entry
);

	logic [ENTRY_W-1:0] cells [STACK_DEPTH];

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [ENTRY_W-1:0] prev_d;
		logic [ENTRY_W-1:0] next_d;

		if (i == 0) begin : g_first
			assign prev_d = push_entry;
		end else begin : g_mid
			assign prev_d = cells[i-1];
		end

		// last cell keeps its contents on pop; it is then beyond the fill level
		if (i == STACK_DEPTH - 1) begin : g_last
			assign next_d = cells[i];
		end else begin : g_inner
			assign next_d = cells[i+1];
		end

		sbm_cell #(
			.ENTRY_W (ENTRY_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.from_prev (prev_d),
			.from_next (next_d),
			.entry     (cells[i])
		);
	end

	assign top_entry = cells[0];

endmodule : sbm_stack
`default_nettype wire

FILE: design/sbm_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbm_out_queue: two-entry report queue
// Decouples the scanner from a stalled report sink.
// ----------------------------------------------------------------------------
module sbm_out_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire sbm_pkg::result_t  din,
	output logic                   full,
	sbm_report_if.source           report
);

	sbm_pkg::result_t slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign pop  = report.valid && report.ready;
	assign full = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign report.valid          = (cnt_q != 2'd0);
	assign report.status         = slot_q[rd_ptr_q].status;
	assign report.offending_char = slot_q[rd_ptr_q].offending_char;
	assign report.line_number    = slot_q[rd_ptr_q].line_number;

endmodule : sbm_out_queue
`default_nettype wire

FILE: verif/source_bracket_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_bracket_matcher_tb: self-checking bench for the bracket matcher
// Streams short C-like files (comments, brackets, newlines, noise) through the
// text channel and checks every status report against a local scanner model.
// The run covers a completely full stack, stack overflow with an ignored tail,
// and applies random idle on both channels plus a long report back-pressure.
// ----------------------------------------------------------------------------
module source_bracket_matcher_tb;

	localparam int STACK_DEPTH = sbm_pkg::DEFAULT_STACK_DEPTH;
	localparam int LINE_BITS   = sbm_pkg::DEFAULT_LINE_BITS;
	localparam int SINK_HOLD   = 300;

	typedef struct {
		logic [7:0] text_byte;
		logic       end_of_file;
		bit         drain_first;
		bit         hold_sink;
		int         phase;
	} text_item_t;

	logic clk;
	logic arst_n;

	sbm_text_if   text_ch();
	sbm_report_if report_ch();

	source_bracket_matcher u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_ch),
		.report(report_ch)
	);

	text_item_t       text_items[$];
	sbm_pkg::result_t expected_reports[$];

	// scanner model state
	sbm_pkg::mode_t       cur_mode;
	bit                   open_kind[STACK_DEPTH];
	logic [LINE_BITS-1:0] open_line[STACK_DEPTH];
	int                   open_depth;
	logic [LINE_BITS-1:0] line_count;
	bit                   fault_seen;

	int src_idle_pct[3] = '{28, 88, 0};
	int snk_idle_pct[3] = '{88, 28, 0};

	bit failed;
	bit byte_taken;
	int drive_phase;
	int hold_requests;
	int holds_served;
	int stall_left;

	// stimulus build state
	int cur_phase;
	bit mark_drain;
	bit mark_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_scan();
		cur_mode   = sbm_pkg::MODE_NORMAL;
		open_depth = 0;
		line_count = LINE_BITS'(1);
		fault_seen = 0;
	endfunction

	function automatic void advance_line();
		if (line_count != '1)
			line_count++;
	endfunction

	function automatic logic [7:0] closer_of(input logic [7:0] opener);
		return (opener == sbm_pkg::CH_LBRACE) ? sbm_pkg::CH_RBRACE : sbm_pkg::CH_RPAREN;
	endfunction

	task automatic scan_text_char(input logic [7:0] c, output bit hit,
		output sbm_pkg::result_t rpt);
		hit = 0;
		rpt = '0;
		if (c == sbm_pkg::CH_SLASH) begin
			cur_mode = sbm_pkg::MODE_SLASH;
		end else if (c == sbm_pkg::CH_NEWLINE) begin
			advance_line();
		end else if (c == sbm_pkg::CH_LPAREN || c == sbm_pkg::CH_LBRACE) begin
			if (open_depth >= STACK_DEPTH) begin
				hit = 1;
				rpt.status = sbm_pkg::ST_OVERFLOW;
				rpt.offending_char = c;
				rpt.line_number = line_count;
			end else begin
				open_kind[open_depth] = (c == sbm_pkg::CH_LBRACE);
				open_line[open_depth] = line_count;
				open_depth++;
			end
		end else if (c == sbm_pkg::CH_RPAREN || c == sbm_pkg::CH_RBRACE) begin
			if (open_depth == 0) begin
				hit = 1;
				rpt.status = sbm_pkg::ST_NO_OPENER;
				rpt.offending_char = c;
				rpt.line_number = line_count;
			end else begin
				open_depth--;
				if (open_kind[open_depth] != (c == sbm_pkg::CH_RBRACE)) begin
					hit = 1;
					rpt.status = sbm_pkg::ST_WRONG_KIND;
					rpt.offending_char = c;
					rpt.line_number = line_count;
				end
			end
		end
	endtask

	task automatic scan_byte(input logic [7:0] c, input logic eof);
		bit               hit;
		sbm_pkg::result_t rpt;
		hit = 0;
		rpt = '0;
		if (!fault_seen) begin
			case (cur_mode)
				sbm_pkg::MODE_SLASH: begin
					if (c == sbm_pkg::CH_SLASH) begin
						cur_mode = sbm_pkg::MODE_LINE_CMT;
					end else if (c == sbm_pkg::CH_STAR) begin
						cur_mode = sbm_pkg::MODE_BLOCK_CMT;
					end else begin
						cur_mode = sbm_pkg::MODE_NORMAL;
						scan_text_char(c, hit, rpt);
					end
				end
				sbm_pkg::MODE_LINE_CMT: begin
					if (c == sbm_pkg::CH_NEWLINE) begin
						advance_line();
						cur_mode = sbm_pkg::MODE_NORMAL;
					end
				end
				sbm_pkg::MODE_BLOCK_CMT: begin
					if (c == sbm_pkg::CH_STAR)
						cur_mode = sbm_pkg::MODE_BLOCK_STAR;
					else if (c == sbm_pkg::CH_NEWLINE)
						advance_line();
				end
				sbm_pkg::MODE_BLOCK_STAR: begin
					if (c == sbm_pkg::CH_SLASH) begin
						cur_mode = sbm_pkg::MODE_NORMAL;
					end else if (c != sbm_pkg::CH_STAR) begin
						if (c == sbm_pkg::CH_NEWLINE)
							advance_line();
						cur_mode = sbm_pkg::MODE_BLOCK_CMT;
					end
				end
				default: begin
					cur_mode = sbm_pkg::MODE_NORMAL;
					scan_text_char(c, hit, rpt);
				end
			endcase
			if (hit) begin
				fault_seen = 1;
				expected_reports.push_back(rpt);
			end else if (eof) begin
				if (open_depth > 0) begin
					rpt.status = sbm_pkg::ST_LEFT_OPEN;
					rpt.offending_char = open_kind[0] ? sbm_pkg::CH_LBRACE : sbm_pkg::CH_LPAREN;
					rpt.line_number = open_line[0];
				end else begin
					rpt.status = sbm_pkg::ST_BALANCED;
					rpt.offending_char = 8'h00;
					rpt.line_number = '0;
				end
				expected_reports.push_back(rpt);
			end
		end
		if (eof)
			clear_scan();
	endtask

	task automatic put(input logic [7:0] b, input logic eof);
		text_item_t it;
		it.text_byte   = b;
		it.end_of_file = eof;
		it.drain_first = mark_drain;
		it.hold_sink   = mark_hold;
		it.phase       = cur_phase;
		mark_drain = 0;
		mark_hold  = 0;
		text_items.push_back(it);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i], i == s.len() - 1);
	endtask

	// mostly well-formed nesting with comments and noise mixed in
	task automatic put_random_file();
		logic [7:0] opened[$];
		logic [7:0] b;
		int         first;
		int         pick;
		int         k;
		first = text_items.size();
		for (int t = $urandom_range(1, 14); t > 0; t--) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				if (opened.size() < 24) begin
					b = $urandom_range(0, 1) ? sbm_pkg::CH_LBRACE : sbm_pkg::CH_LPAREN;
					opened.push_back(b);
					put(b, 0);
				end
			end else if (pick < 38) begin
				if (opened.size() > 0) begin
					b = closer_of(opened.pop_back());
					if ($urandom_range(0, 19) == 0)
						b = (b == sbm_pkg::CH_RBRACE) ? sbm_pkg::CH_RPAREN : sbm_pkg::CH_RBRACE;
					put(b, 0);
				end else if ($urandom_range(0, 3) == 0) begin
					put($urandom_range(0, 1) ? sbm_pkg::CH_RBRACE : sbm_pkg::CH_RPAREN, 0);
				end
			end else if (pick < 48) begin
				put(sbm_pkg::CH_NEWLINE, 0);
			end else if (pick < 56) begin
				put(sbm_pkg::CH_SLASH, 0);
				put(sbm_pkg::CH_SLASH, 0);
				for (k = $urandom_range(0, 6); k > 0; k--)
					put(8'($urandom_range(0, 255)), 0);
				put(sbm_pkg::CH_NEWLINE, 0);
			end else if (pick < 66) begin
				put(sbm_pkg::CH_SLASH, 0);
				put(sbm_pkg::CH_STAR, 0);
				for (k = $urandom_range(0, 8); k > 0; k--) begin
					case ($urandom_range(0, 3))
						0: put(sbm_pkg::CH_STAR, 0);
						1: put(sbm_pkg::CH_NEWLINE, 0);
						2: put(sbm_pkg::CH_SLASH, 0);
						default: put(8'($urandom_range(0, 255)), 0);
					endcase
				end
				for (k = $urandom_range(1, 3); k > 0; k--)
					put(sbm_pkg::CH_STAR, 0);
				put(sbm_pkg::CH_SLASH, 0);
			end else if (pick < 70) begin
				put(sbm_pkg::CH_SLASH, 0);
				put(8'($urandom_range(0, 255)), 0);
			end else begin
				put(8'($urandom_range(0, 255)), 0);
			end
		end
		if ($urandom_range(0, 4) != 0)
			while (opened.size() > 0)
				put(closer_of(opened.pop_back()), 0);
		if (text_items.size() == first)
			put(8'($urandom_range(0, 255)), 0);
		text_items[$].end_of_file = 1'b1;
	endtask

	task automatic put_random_phase(input int n_items);
		int target;
		target = text_items.size() + n_items;
		while (text_items.size() < target)
			put_random_file();
	endtask

	// predictor and checker: both sample at the rising edge
	always @(posedge clk) begin
		sbm_pkg::result_t want;
		byte_taken = arst_n && text_ch.valid && text_ch.ready;
		if (byte_taken)
			scan_byte(text_ch.text_byte, text_ch.end_of_file);
		if (arst_n && report_ch.valid && report_ch.ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report: status %0d char %0h line %0d",
					report_ch.status, report_ch.offending_char, report_ch.line_number);
				failed = 1;
			end else begin
				want = expected_reports.pop_front();
				if (report_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, report_ch.status);
					failed = 1;
				end
				if (report_ch.offending_char !== want.offending_char) begin
					$error("offending_char: expected %0h, got %0h",
						want.offending_char, report_ch.offending_char);
					failed = 1;
				end
				if (report_ch.line_number !== want.line_number) begin
					$error("line_number: expected %0d, got %0d",
						want.line_number, report_ch.line_number);
					failed = 1;
				end
			end
		end
	end

	// text driver
	always @(negedge clk) begin
		text_item_t head;
		if (arst_n) begin
			if (byte_taken)
				void'(text_items.pop_front());
			if (!(text_ch.valid && !byte_taken)) begin
				if (text_items.size() == 0) begin
					text_ch.valid <= 1'b0;
				end else begin
					head = text_items[0];
					if (head.drain_first && expected_reports.size() != 0) begin
						text_ch.valid <= 1'b0;
					end else begin
						text_items[0].drain_first = 0;
						drive_phase <= head.phase;
						if ($urandom_range(0, 99) < src_idle_pct[head.phase]) begin
							text_ch.valid <= 1'b0;
						end else begin
							if (head.hold_sink) begin
								hold_requests <= hold_requests + 1;
								text_items[0].hold_sink = 0;
							end
							text_ch.valid       <= 1'b1;
							text_ch.text_byte   <= head.text_byte;
							text_ch.end_of_file <= head.end_of_file;
						end
					end
				end
			end
		end
	end

	// report receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				report_ch.ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				stall_left = SINK_HOLD;
				report_ch.ready <= 1'b0;
			end else begin
				report_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct[drive_phase]);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [7:0] b;
		logic [7:0] opened[$];
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = 8'h00;
		text_ch.end_of_file = 1'b0;
		report_ch.ready = 1'b0;
		failed = 0;
		byte_taken = 0;
		drive_phase = 0;
		hold_requests = 0;
		holds_served = 0;
		stall_left = 0;
		cur_phase = 0;
		mark_drain = 0;
		mark_hold = 0;
		clear_scan();

		// directed: byte extremes, fault on the end byte, ignored tail after a
		// fault, star run closing a comment, slash as plain text, open comment
		put(8'h00, 1);
		put(8'hFF, 1);
		put_str("(\n}");
		put_str("}x");
		put_str("/*(**/{\n");
		put_str("//)\n/x)");
		put_str("(/*");
		put_str("{}");

		put_random_phase(140);
		mark_drain = 1;
		cur_phase = 1;
		put_random_phase(140);
		mark_drain = 1;
		cur_phase = 2;
		put_random_phase(140);

		// back-pressure burst: every single-byte file yields a report
		mark_drain = 1;
		mark_hold = 1;
		for (int i = 0; i < 16; i++)
			put(8'($urandom_range(0, 255)), 1);

		// stack filled exactly, then emptied
		mark_drain = 1;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			b = $urandom_range(0, 1) ? sbm_pkg::CH_LBRACE : sbm_pkg::CH_LPAREN;
			opened.push_back(b);
			put(b, 0);
		end
		while (opened.size() > 0) begin
			b = closer_of(opened.pop_back());
			put(b, opened.size() == 0);
		end

		// overflow followed by an ignored tail
		for (int i = 0; i <= STACK_DEPTH; i++)
			put(i[0] ? sbm_pkg::CH_LPAREN : sbm_pkg::CH_LBRACE, 0);
		put_str("x)");

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		while (text_items.size() != 0 || expected_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (!failed && expected_reports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule : source_bracket_matcher_tb
